@@ rtl/pld_pkg.sv @@
`default_nettype none
package pld_pkg;

   localparam int MAX_PARTICLES = 1024;
   localparam int ADDR_W = $clog2(MAX_PARTICLES);
   localparam int IDX_W = 10;
   localparam int POS_W = 32;
   localparam int CUT_W = 24;
   localparam int VAL_W = 32;
   localparam int CSR_IDX_W = 3;

   // Stored particle record: type, z, y, x.
   localparam int REC_W = 3 * POS_W + 1;

   // Opcodes of a request transaction.
   localparam logic [1:0] OPC_LOAD = 2'd0;
   localparam logic [1:0] OPC_PAIR = 2'd1;
   localparam logic [1:0] OPC_READ = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_X = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Y = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BOX_Z = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT00 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT01 = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CUT11 = 3'd5;

   localparam logic [31:0] BOX_RESET = 32'd10485760;
   localparam logic [CUT_W-1:0] CUT_RESET = 24'd786432;

   // 7.5/pi in Q.28.
   localparam logic [31:0] WEIGHT_K = 32'd640842446;

   // Divider step counts for the three kinds of division.
   localparam logic [6:0] DIV_STEPS_MOD = 7'd33;
   localparam logic [6:0] DIV_STEPS_U = 7'd44;
   localparam logic [6:0] DIV_STEPS_C = 7'd64;

   localparam logic [4:0] SQRT_LAST = 5'd23;

   typedef enum logic [4:0] {
      DP_NONE,
      DP_LATCH,
      DP_LOAD,
      DP_RD_PI,
      DP_CAP_I_RD_PJ,
      DP_CAP_J,
      DP_AX_START,
      DP_AX_FIN,
      DP_MUL_MAG,
      DP_ACC,
      DP_SQRT_INIT,
      DP_SQRT_STEP,
      DP_U_START,
      DP_U_FIN,
      DP_MUL_U,
      DP_MUL_K,
      DP_MUL_DONE,
      DP_C_START,
      DP_C_FIN,
      DP_WGT,
      DP_RD_DJ,
      DP_ADD_J,
      DP_RD_DI,
      DP_ADD_I,
      DP_DENS,
      DP_PUBLISH
   } dp_op_type;

   typedef struct packed {
      dp_op_type  op;
      logic [1:0] axis;
   } dp_cmd_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic       idx_ok;
      logic       div_done;
      logic       beyond;
      logic       c_clip;
   } dp_status_type;

   typedef struct packed {
      logic [63:0] dividend;
      logic [32:0] divisor;
      logic [6:0]  steps;
   } div_req_type;

endpackage
`default_nettype wire

@@ rtl/pld_div.sv @@
`default_nettype none
module pld_div (
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       start,
   input  pld_pkg::div_req_type      req,
   output logic                      done,
   output logic [63:0]               quotient,
   output logic [32:0]               remainder
);
   import pld_pkg::*;

   logic        busy_ff, busy_in;
   logic        done_ff, done_in;
   logic [6:0]  cnt_ff, cnt_in;
   logic [63:0] dvd_ff, dvd_in;
   logic [32:0] dsr_ff, dsr_in;
   logic [63:0] q_ff, q_in;
   logic [32:0] rem_ff, rem_in;
   logic [33:0] partial;
   logic [33:0] trial;
   logic        fits;

   // One quotient bit per cycle, dividend arrives left aligned.
   always_comb begin
      partial = {rem_ff, dvd_ff[63]};
      trial = partial - {1'b0, dsr_ff};
      fits = partial >= {1'b0, dsr_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in = cnt_ff;
      dvd_in = dvd_ff;
      dsr_in = dsr_ff;
      q_in = q_ff;
      rem_in = rem_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = req.steps;
         dvd_in = req.dividend;
         dsr_in = req.divisor;
         q_in = '0;
         rem_in = '0;
      end else if (busy_ff) begin
         rem_in = fits ? trial[32:0] : partial[32:0];
         q_in = {q_ff[62:0], fits};
         dvd_in = {dvd_ff[62:0], 1'b0};
         cnt_in = cnt_ff - 7'd1;
         if (cnt_ff == 7'd1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff <= cnt_in;
      dvd_ff <= dvd_in;
      dsr_ff <= dsr_in;
      q_ff <= q_in;
      rem_ff <= rem_in;
   end

   assign done = done_ff;
   assign quotient = q_ff;
   assign remainder = rem_ff;

endmodule
`default_nettype wire

@@ rtl/pld_datapath.sv @@
`default_nettype none
module pld_datapath (
   input  wire                           clock,
   input  wire                           reset,
   input  pld_pkg::dp_cmd_type           cmd,
   output pld_pkg::dp_status_type        status,
   input  wire                           csr_we,
   input  wire [pld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [31:0]                    csr_data,
   input  wire [1:0]                     req_opcode,
   input  wire [pld_pkg::IDX_W-1:0]      req_first_index,
   input  wire [pld_pkg::IDX_W-1:0]      req_second_index,
   input  wire [pld_pkg::POS_W-1:0]      req_pos_x,
   input  wire [pld_pkg::POS_W-1:0]      req_pos_y,
   input  wire [pld_pkg::POS_W-1:0]      req_pos_z,
   input  wire                           req_particle_type,
   output logic [pld_pkg::VAL_W-1:0]     rsp_value,
   output logic                          rsp_within_cutoff,
   output logic                          rsp_saturated
);
   import pld_pkg::*;

   // Configuration registers.
   logic [31:0]      box_x_ff, box_y_ff, box_z_ff;
   logic [CUT_W-1:0] cut00_ff, cut01_ff, cut11_ff;

   // Latched request.
   logic [1:0]       op_ff;
   logic [IDX_W-1:0] i_ff, j_ff;
   logic [REC_W-1:0] rec_in_ff;

   logic [REC_W-1:0] pos_mem [MAX_PARTICLES];
   logic [VAL_W-1:0] dens_mem [MAX_PARTICLES];
   logic [REC_W-1:0] pos_rd_ff;
   logic [VAL_W-1:0] dens_rd_ff;
   logic [ADDR_W-1:0] addr_i, addr_j;

   logic [REC_W-1:0] pi_ff, pj_ff;
   logic [CUT_W-1:0] r_ff;
   logic [47:0]      rr_ff;
   logic [32:0]      m_ff;
   logic             neg_ff;
   logic [31:0]      mag_ff;
   logic [63:0]      prod_ff;
   logic [63:0]      d2_ff;
   logic [47:0]      sq_rem_ff, sq_res_ff, sq_bit_ff;
   logic [20:0]      u_ff;
   logic [43:0]      c_ff;
   logic             clip_ff;
   logic [31:0]      w_ff;
   logic [VAL_W-1:0] res_value_ff;
   logic             res_within_ff, res_sat_ff;
   logic [VAL_W-1:0] rsp_value_ff;
   logic             rsp_within_ff, rsp_sat_ff;

   logic             div_start, div_done;
   div_req_type      div_req;
   logic [63:0]      div_q;
   logic [32:0]      div_rem;

   logic [31:0]      ax_a, ax_b, ax_len;
   logic [32:0]      ax_diff, ax_abs, ax_m;
   logic [32:0]      ax_r;
   logic [31:0]      mul_a, mul_b;
   logic [47:0]      sq_trial;
   logic [CUT_W-1:0] r_sel;
   logic [32:0]      dens_sum;
   logic [VAL_W-1:0] dens_sat;

   pld_div u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .req       (div_req),
      .done      (div_done),
      .quotient  (div_q),
      .remainder (div_rem)
   );

   assign addr_i = ADDR_W'(i_ff);
   assign addr_j = ADDR_W'(j_ff);

   always_comb begin
      unique case (cmd.axis)
         2'd0: begin
            ax_a = pi_ff[31:0];
            ax_b = pj_ff[31:0];
            ax_len = box_x_ff;
         end
         2'd1: begin
            ax_a = pi_ff[63:32];
            ax_b = pj_ff[63:32];
            ax_len = box_y_ff;
         end
         default: begin
            ax_a = pi_ff[95:64];
            ax_b = pj_ff[95:64];
            ax_len = box_z_ff;
         end
      endcase
      ax_diff = {1'b0, ax_b} - {1'b0, ax_a};
      ax_abs = ax_diff[32] ? (33'd0 - ax_diff) : ax_diff;
      // A zero box length stands for a full 2^32 wrap.
      ax_m = (ax_len == 32'd0) ? {1'b1, 32'd0} : {1'b0, ax_len};
      ax_r = (neg_ff && div_rem != 33'd0) ? (m_ff - div_rem) : div_rem;
   end

   always_comb begin
      div_start = 1'b0;
      div_req.dividend = {ax_abs, 31'd0};
      div_req.divisor = ax_m;
      div_req.steps = DIV_STEPS_MOD;
      case (cmd.op)
         DP_AX_START: div_start = 1'b1;
         DP_U_START: begin
            div_start = 1'b1;
            div_req.dividend = {r_ff - sq_res_ff[CUT_W-1:0], 40'd0};
            div_req.divisor = {9'd0, r_ff};
            div_req.steps = DIV_STEPS_U;
         end
         DP_C_START: begin
            div_start = 1'b1;
            div_req.dividend = {c_ff, 20'd0};
            div_req.divisor = {9'd0, r_ff};
            div_req.steps = DIV_STEPS_C;
         end
         default: ;
      endcase
   end

   // One shared 32 x 32 multiplier, result registered.
   always_comb begin
      mul_a = mag_ff;
      mul_b = mag_ff;
      case (cmd.op)
         DP_MUL_U: begin
            mul_a = {11'd0, u_ff};
            mul_b = {11'd0, u_ff};
         end
         DP_MUL_K: begin
            mul_a = {11'd0, prod_ff[40:20]};
            mul_b = WEIGHT_K;
         end
         default: ;
      endcase
   end

   always_comb begin
      sq_trial = sq_res_ff + sq_bit_ff;
      // The cutoff table is symmetric in the two types.
      if (pi_ff[REC_W-1] != pos_rd_ff[REC_W-1]) begin
         r_sel = cut01_ff;
      end else if (!pi_ff[REC_W-1]) begin
         r_sel = cut00_ff;
      end else begin
         r_sel = cut11_ff;
      end
      dens_sum = {1'b0, dens_rd_ff} + {1'b0, w_ff};
      dens_sat = dens_sum[32] ? '1 : dens_sum[VAL_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         box_x_ff <= BOX_RESET;
         box_y_ff <= BOX_RESET;
         box_z_ff <= BOX_RESET;
         cut00_ff <= CUT_RESET;
         cut01_ff <= CUT_RESET;
         cut11_ff <= CUT_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_BOX_X: box_x_ff <= csr_data;
            CSR_BOX_Y: box_y_ff <= csr_data;
            CSR_BOX_Z: box_z_ff <= csr_data;
            CSR_CUT00: cut00_ff <= csr_data[CUT_W-1:0];
            CSR_CUT01: cut01_ff <= csr_data[CUT_W-1:0];
            CSR_CUT11: cut11_ff <= csr_data[CUT_W-1:0];
            default: ;
         endcase
      end
   end

   // Particle and density stores, registered reads.
   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) begin
         pos_mem[addr_i] <= rec_in_ff;
      end
      if (cmd.op == DP_RD_PI) begin
         pos_rd_ff <= pos_mem[addr_i];
      end else if (cmd.op == DP_CAP_I_RD_PJ) begin
         pos_rd_ff <= pos_mem[addr_j];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == DP_LOAD) begin
         dens_mem[addr_i] <= '0;
      end else if (cmd.op == DP_ADD_J) begin
         dens_mem[addr_j] <= dens_sat;
      end else if (cmd.op == DP_ADD_I) begin
         dens_mem[addr_i] <= dens_sat;
      end
      if (cmd.op == DP_RD_DI) begin
         dens_rd_ff <= dens_mem[addr_i];
      end else if (cmd.op == DP_RD_DJ) begin
         dens_rd_ff <= dens_mem[addr_j];
      end
   end

   always_ff @(posedge clock) begin
      rr_ff <= {24'd0, r_ff} * {24'd0, r_ff};
      case (cmd.op)
         DP_LATCH: begin
            op_ff <= req_opcode;
            i_ff <= req_first_index;
            j_ff <= req_second_index;
            rec_in_ff <= {req_particle_type, req_pos_z, req_pos_y, req_pos_x};
            clip_ff <= 1'b0;
            res_value_ff <= '0;
            res_within_ff <= 1'b0;
            res_sat_ff <= 1'b0;
         end
         DP_CAP_I_RD_PJ: pi_ff <= pos_rd_ff;
         DP_CAP_J: begin
            pj_ff <= pos_rd_ff;
            r_ff <= r_sel;
            d2_ff <= '0;
         end
         DP_AX_START: begin
            m_ff <= ax_m;
            neg_ff <= ax_diff[32];
         end
         DP_AX_FIN: begin
            if ({ax_r, 1'b0} > {1'b0, m_ff}) begin
               mag_ff <= 32'(m_ff - ax_r);
            end else begin
               mag_ff <= ax_r[31:0];
            end
         end
         DP_MUL_MAG, DP_MUL_U, DP_MUL_K: prod_ff <= mul_a * mul_b;
         DP_ACC: d2_ff <= d2_ff + prod_ff;
         DP_SQRT_INIT: begin
            sq_rem_ff <= d2_ff[47:0];
            sq_res_ff <= '0;
            sq_bit_ff <= 48'd1 << 46;
         end
         DP_SQRT_STEP: begin
            if (sq_rem_ff >= sq_trial) begin
               sq_rem_ff <= sq_rem_ff - sq_trial;
               sq_res_ff <= (sq_res_ff >> 1) + sq_bit_ff;
            end else begin
               sq_res_ff <= sq_res_ff >> 1;
            end
            sq_bit_ff <= sq_bit_ff >> 2;
         end
         DP_U_FIN: u_ff <= div_q[20:0];
         DP_MUL_DONE: c_ff <= prod_ff[63:20];
         DP_C_FIN: begin
            c_ff <= div_q[43:0];
            if (div_q[63:44] != 20'd0) begin
               clip_ff <= 1'b1;
            end
         end
         DP_WGT: w_ff <= clip_ff ? '1 : c_ff[43:12];
         DP_ADD_J: clip_ff <= clip_ff | dens_sum[32];
         DP_ADD_I: begin
            res_value_ff <= w_ff;
            res_within_ff <= 1'b1;
            res_sat_ff <= clip_ff | dens_sum[32];
         end
         DP_DENS: res_value_ff <= dens_rd_ff;
         DP_PUBLISH: begin
            rsp_value_ff <= res_value_ff;
            rsp_within_ff <= res_within_ff;
            rsp_sat_ff <= res_sat_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      status.opcode = op_ff;
      status.idx_ok = ({1'b0, i_ff} < (IDX_W + 1)'(MAX_PARTICLES))
         && ({1'b0, j_ff} < (IDX_W + 1)'(MAX_PARTICLES));
      status.div_done = div_done;
      status.beyond = (r_ff == '0) || (d2_ff >= {16'd0, rr_ff});
      status.c_clip = div_q[63:44] != 20'd0;
   end

   assign rsp_value = rsp_value_ff;
   assign rsp_within_cutoff = rsp_within_ff;
   assign rsp_saturated = rsp_sat_ff;

endmodule
`default_nettype wire

@@ rtl/pld_ctrl.sv @@
`default_nettype none
module pld_ctrl (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   input  pld_pkg::dp_status_type     status,
   output pld_pkg::dp_cmd_type        cmd
);
   import pld_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_DECODE,
      S_LOAD,
      S_RD_PI,
      S_RD_PJ,
      S_CAP_J,
      S_AX_START,
      S_AX_WAIT,
      S_MUL_MAG,
      S_ACC,
      S_CMP,
      S_SQRT_INIT,
      S_SQRT,
      S_U_START,
      S_U_WAIT,
      S_MUL_U,
      S_MUL_K,
      S_MUL_DONE,
      S_C_START,
      S_C_WAIT,
      S_WGT,
      S_RD_DJ,
      S_ADD_J,
      S_RD_DI,
      S_ADD_I,
      S_RD_D,
      S_DENS,
      S_FINISH
   } state_type;

   state_type  state_ff, state_in;
   logic [1:0] ax_ff, ax_in;
   logic [4:0] sq_cnt_ff, sq_cnt_in;
   logic [1:0] pass_ff, pass_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       slot_free;

   assign slot_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in = state_ff;
      ax_in = ax_ff;
      sq_cnt_in = sq_cnt_ff;
      pass_in = pass_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd.op = DP_NONE;
      cmd.axis = ax_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.op = DP_LATCH;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            if (!status.idx_ok) begin
               state_in = S_FINISH;
            end else begin
               unique case (status.opcode)
                  OPC_LOAD: state_in = S_LOAD;
                  OPC_PAIR: state_in = S_RD_PI;
                  OPC_READ: state_in = S_RD_D;
                  default: state_in = S_FINISH;
               endcase
            end
         end
         S_LOAD: begin
            cmd.op = DP_LOAD;
            state_in = S_FINISH;
         end
         S_RD_PI: begin
            cmd.op = DP_RD_PI;
            state_in = S_RD_PJ;
         end
         S_RD_PJ: begin
            cmd.op = DP_CAP_I_RD_PJ;
            state_in = S_CAP_J;
         end
         S_CAP_J: begin
            cmd.op = DP_CAP_J;
            ax_in = 2'd0;
            state_in = S_AX_START;
         end
         S_AX_START: begin
            cmd.op = DP_AX_START;
            state_in = S_AX_WAIT;
         end
         S_AX_WAIT: begin
            if (status.div_done) begin
               cmd.op = DP_AX_FIN;
               state_in = S_MUL_MAG;
            end
         end
         S_MUL_MAG: begin
            cmd.op = DP_MUL_MAG;
            state_in = S_ACC;
         end
         S_ACC: begin
            cmd.op = DP_ACC;
            if (ax_ff == 2'd2) begin
               state_in = S_CMP;
            end else begin
               ax_in = ax_ff + 2'd1;
               state_in = S_AX_START;
            end
         end
         S_CMP: begin
            state_in = status.beyond ? S_FINISH : S_SQRT_INIT;
         end
         S_SQRT_INIT: begin
            cmd.op = DP_SQRT_INIT;
            sq_cnt_in = '0;
            state_in = S_SQRT;
         end
         S_SQRT: begin
            cmd.op = DP_SQRT_STEP;
            sq_cnt_in = sq_cnt_ff + 5'd1;
            if (sq_cnt_ff == SQRT_LAST) begin
               state_in = S_U_START;
            end
         end
         S_U_START: begin
            cmd.op = DP_U_START;
            state_in = S_U_WAIT;
         end
         S_U_WAIT: begin
            if (status.div_done) begin
               cmd.op = DP_U_FIN;
               state_in = S_MUL_U;
            end
         end
         S_MUL_U: begin
            cmd.op = DP_MUL_U;
            state_in = S_MUL_K;
         end
         S_MUL_K: begin
            cmd.op = DP_MUL_K;
            state_in = S_MUL_DONE;
         end
         S_MUL_DONE: begin
            cmd.op = DP_MUL_DONE;
            pass_in = '0;
            state_in = S_C_START;
         end
         S_C_START: begin
            cmd.op = DP_C_START;
            state_in = S_C_WAIT;
         end
         S_C_WAIT: begin
            if (status.div_done) begin
               cmd.op = DP_C_FIN;
               // Three divisions by the cutoff, cut short once the value clips.
               if (status.c_clip || pass_ff == 2'd2) begin
                  state_in = S_WGT;
               end else begin
                  pass_in = pass_ff + 2'd1;
                  state_in = S_C_START;
               end
            end
         end
         S_WGT: begin
            cmd.op = DP_WGT;
            state_in = S_RD_DJ;
         end
         S_RD_DJ: begin
            cmd.op = DP_RD_DJ;
            state_in = S_ADD_J;
         end
         S_ADD_J: begin
            cmd.op = DP_ADD_J;
            state_in = S_RD_DI;
         end
         S_RD_DI: begin
            cmd.op = DP_RD_DI;
            state_in = S_ADD_I;
         end
         S_ADD_I: begin
            cmd.op = DP_ADD_I;
            state_in = S_FINISH;
         end
         S_RD_D: begin
            cmd.op = DP_RD_DI;
            state_in = S_DENS;
         end
         S_DENS: begin
            cmd.op = DP_DENS;
            state_in = S_FINISH;
         end
         S_FINISH: begin
            if (slot_free) begin
               cmd.op = DP_PUBLISH;
               rsp_valid_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         ax_ff <= '0;
         sq_cnt_ff <= '0;
         pass_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         ax_ff <= ax_in;
         sq_cnt_ff <= sq_cnt_in;
         pass_ff <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

@@ rtl/pair_local_density_accumulator_top.sv @@
// Pair local-density accumulator.
// Request channel (req_valid / req_stall): one transaction per operation.
// Opcode 0 loads a particle and clears its density, opcode 1 accumulates the
// weight of a particle pair into both densities, opcode 2 reads a density.
// Response channel (rsp_valid / rsp_stall): exactly one transaction per
// request, in order, held in an output register until taken.
// Configuration (csr_valid / csr_ready, always ready) writes box lengths and
// cutoffs; write only while no request is in flight.
// A pair request runs three 33-step divides for the periodic wrap and, for a
// pair inside its cutoff, a 24-step square root, a 44-step and up to three
// 64-step divides, all divides on the shared bit-serial divider. One request
// is in work at a time: the next is taken only once the block is idle again.
// A new request is taken while the previous response is still stalled; the
// block then waits at its end until the output register is free.
// Reset restores the configuration defaults and empties the output register;
// particle and density stores hold no defined value until loaded.
`default_nettype none
module pair_local_density_accumulator_top (
   input  wire                           clock,
   input  wire                           reset,
   input  wire                           req_valid,
   output logic                          req_stall,
   input  wire [1:0]                     req_opcode,
   input  wire [pld_pkg::IDX_W-1:0]      req_first_index,
   input  wire [pld_pkg::IDX_W-1:0]      req_second_index,
   input  wire [pld_pkg::POS_W-1:0]      req_pos_x,
   input  wire [pld_pkg::POS_W-1:0]      req_pos_y,
   input  wire [pld_pkg::POS_W-1:0]      req_pos_z,
   input  wire                           req_particle_type,
   output logic                          rsp_valid,
   input  wire                           rsp_stall,
   output logic [pld_pkg::VAL_W-1:0]     rsp_value,
   output logic                          rsp_within_cutoff,
   output logic                          rsp_saturated,
   input  wire                           csr_valid,
   output logic                          csr_ready,
   input  wire [pld_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire [31:0]                    csr_data
);
   import pld_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;

   assign csr_ready = 1'b1;

   pld_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   pld_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .csr_we            (csr_valid && csr_ready),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .req_opcode        (req_opcode),
      .req_first_index   (req_first_index),
      .req_second_index  (req_second_index),
      .req_pos_x         (req_pos_x),
      .req_pos_y         (req_pos_y),
      .req_pos_z         (req_pos_z),
      .req_particle_type (req_particle_type),
      .rsp_value         (rsp_value),
      .rsp_within_cutoff (rsp_within_cutoff),
      .rsp_saturated     (rsp_saturated)
   );

endmodule
`default_nettype wire
